FILE: sv/ectc_pkg.sv
// Shared types, character codes and lookup functions of the eCIGAR to CIGAR transcoder.
package ectc_pkg;

  localparam int RUN_WIDTH_DEF   = 16;
  localparam int DIGIT_DEPTH_DEF = 10;

  localparam logic [7:0] CH_X      = 8'h58;  // 'X'
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_I      = 8'h49;  // 'I'
  localparam logic [7:0] CH_D      = 8'h44;  // 'D'
  localparam logic [7:0] CH_N      = 8'h4E;  // 'N'
  localparam logic [7:0] CH_S      = 8'h53;  // 'S'
  localparam logic [7:0] CH_H      = 8'h48;  // 'H'
  localparam logic [7:0] CH_A      = 8'h41;  // 'A'
  localparam logic [7:0] CH_C      = 8'h43;  // 'C'
  localparam logic [7:0] CH_G      = 8'h47;  // 'G'
  localparam logic [7:0] CH_T      = 8'h54;  // 'T'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [3:0] DIGIT_HI  = 4'h3;   // upper nibble of an ASCII digit

  // Classification of an incoming character against the current state.
  typedef enum logic [2:0] {
    CLS_SKIP,    // opening bracket, or anything while discarding
    CLS_DIGBUF,  // digit buffered behind an open mismatch run
    CLS_BASE,    // base letter, extends the run
    CLS_PASS,    // digit passed straight through
    CLS_MAP,     // operation character with a CIGAR mapping
    CLS_ERR      // unmapped character or digit buffer overflow
  } cls_t;

  // Source of an emitted result.
  typedef enum logic [1:0] {
    SEL_NUM,   // one decimal digit of the run count
    SEL_X,     // the mismatch operation letter
    SEL_BUF,   // one buffered digit
    SEL_ONE    // the item's own result: mapped char, passed digit, error or bare end
  } sel_t;

  typedef struct packed {
    logic take;
    logic conv_start;
    logic conv_step;
    logic num_adv;
    logic buf_adv;
    logic emit;
    sel_t sel;
    logic last;
    logic eor;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    cls_t cls;        // class of the character on the input port
    logic eos_in;     // end-of-string flag on the input port
    logic eos_q;      // end-of-string flag of the item in work
    logic run_nz;     // mismatch run is open
    logic slot_free;  // output register can take a result this cycle
    logic conv_done;
    logic num_skip;   // current decimal digit is a leading zero
    logic num_zero;   // decimal pointer at the units digit
    logic buf_end;    // all buffered digits sent
  } dp_stat_t;

  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] m;
    unique case (c)
      CH_EQ:     m = CH_EQ;
      CH_PLUS:   m = CH_I;
      CH_MINUS:  m = CH_D;
      CH_STAR:   m = CH_N;
      CH_PCT:    m = CH_N;
      CH_SLASH:  m = CH_N;
      CH_RPAREN: m = CH_S;
      CH_RBRACK: m = CH_H;
      default:   m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic is_base(input logic [7:0] c);
    return (c == CH_A) || (c == CH_C) || (c == CH_G) || (c == CH_T) || (c == CH_N);
  endfunction

endpackage

FILE: sv/ecig_in_if.sv
// Input channel: one extended-CIGAR character per transfer.
interface ecig_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ecig_char;
  logic       end_of_string;

  modport source (output valid, output ecig_char, output end_of_string, input ready);
  modport sink   (input valid, input ecig_char, input end_of_string, output ready);
endinterface

FILE: sv/cig_out_if.sv
// Output channel: one CIGAR result per transfer.
interface cig_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cigar_char;
  logic       has_char;
  logic       is_error;
  logic       last_of_run;
  logic       end_of_record;

  modport source (output valid, output cigar_char, output has_char, output is_error,
                  output last_of_run, output end_of_record, input ready);
  modport sink   (input valid, input cigar_char, input has_char, input is_error,
                  input last_of_run, input end_of_record, output ready);
endinterface

FILE: sv/ecigar_to_cigar_transcoder.sv
// Top level of the eCIGAR to SAM CIGAR transcoder: controller, datapath and checks.
//
// Characters of an extended CIGAR string enter on ecig_in, one per transfer, with
// end_of_string set on the final one. CIGAR results leave on cigar_out, one per
// transfer; last_of_run marks the final result of an input character and
// end_of_record the final result of the string.
// Brackets, buffered digits, base letters and characters ignored after an error
// produce no result of their own. A character that produces results is taken in,
// then its results leave one per transfer while the receiver is ready.
// Closing a mismatch run first converts the count (shift-and-add-3, one bit per
// cycle) and skips its leading zeros; a run closed by an operation then sends its
// buffered digits before the operation's own result. An end-of-string character
// with no result of its own passes through a check state for an open run.
// ecig_in is ready whenever the controller is idle, even while the last result
// still sits in the output register; while results are being emitted the input
// is held off. A stalled receiver simply freezes emission, nothing is lost.
// Reset (rst, synchronous) closes any open run, empties the digit buffer, clears
// the error state and drops a result not yet transferred.
module ecigar_to_cigar_transcoder #(
  parameter int RUN_WIDTH   = ectc_pkg::RUN_WIDTH_DEF,
  parameter int DIGIT_DEPTH = ectc_pkg::DIGIT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ecig_in_if.sink    ecig_in,
  cig_out_if.source  cigar_out
);
  import ectc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // Input is taken only by the idle controller; the ready line comes from it alone.
  assign ecig_in.ready = in_ready;

  ectc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ecig_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ectc_dp #(
    .RUN_WIDTH   (RUN_WIDTH),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ecig_char     (ecig_in.ecig_char),
    .end_of_string (ecig_in.end_of_string),
    .cmd           (cmd),
    .stat          (stat),
    .out_ch        (cigar_out)
  );

`ifndef SYNTH
  // A result is only written when the output register is empty or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!cigar_out.valid || cigar_out.ready))
    else $error("result register overwritten before transfer");

  // Intake and emission never happen in the same cycle.
  a_take_excl_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !cmd.emit)
    else $error("input taken while emitting a result");

  // The end of a record is always the last result of its character.
  a_eor_is_last: assert property (@(posedge clk) disable iff (rst)
    (cigar_out.valid && cigar_out.end_of_record) |-> cigar_out.last_of_run)
    else $error("end_of_record without last_of_run");

  // Error results carry no character.
  a_err_no_char: assert property (@(posedge clk) disable iff (rst)
    (cigar_out.valid && cigar_out.is_error) |-> !cigar_out.has_char)
    else $error("error result carries a character");
`endif

endmodule

FILE: sv/ectc_dp.sv
// Datapath of the transcoder: run counter, digit buffer, decimal converter and result register.
module ectc_dp #(
  parameter int RUN_WIDTH   = ectc_pkg::RUN_WIDTH_DEF,
  parameter int DIGIT_DEPTH = ectc_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           ecig_char,
  input  logic                 end_of_string,
  input  ectc_pkg::ctrl_cmd_t  cmd,
  output ectc_pkg::dp_stat_t   stat,
  cig_out_if.source            out_ch
);
  import ectc_pkg::*;

  localparam int NumDig = (RUN_WIDTH * 30103) / 100000 + 1;
  localparam int NpW    = $clog2(NumDig);
  localparam int CntW   = $clog2(DIGIT_DEPTH + 1);
  localparam int IdxW   = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
  localparam int CcW    = $clog2(RUN_WIDTH + 1);

  logic [RUN_WIDTH-1:0] run;
  logic [CntW-1:0]      count;
  logic                 discarding;
  logic [3:0]           digits [DIGIT_DEPTH];

  logic [7:0] c_q;
  logic       eos_q;
  cls_t       cls_q;
  cls_t       cls;

  logic [RUN_WIDTH-1:0] sh;
  logic [3:0]           bcd [NumDig];
  logic [3:0]           adj [NumDig];
  logic [CcW-1:0]       conv_cnt;
  logic [NpW-1:0]       num_ptr;
  logic                 started;
  logic [CntW-1:0]      buf_ptr;
  logic [3:0]           cur_dig;

  logic       out_valid;
  logic [7:0] res_char;
  logic       res_has;
  logic       res_err;
  logic       res_last;
  logic       res_eor;
  logic [7:0] pick_char;
  logic       pick_has;
  logic       pick_err;

  logic is_digit;
  logic run_nz;

  assign is_digit = (ecig_char >= CH_ZERO) && (ecig_char <= CH_NINE);
  assign run_nz   = (run != '0);

  always_comb begin
    if (discarding || ecig_char == CH_LBRACK || ecig_char == CH_LPAREN) begin
      cls = CLS_SKIP;
    end else if (is_digit) begin
      if (!run_nz) cls = CLS_PASS;
      else if (count < CntW'(DIGIT_DEPTH)) cls = CLS_DIGBUF;
      else cls = CLS_ERR;
    end else if (is_base(ecig_char)) begin
      cls = CLS_BASE;
    end else if (map_char(ecig_char) != 8'h00) begin
      cls = CLS_MAP;
    end else begin
      cls = CLS_ERR;
    end
  end

  // Item state: run, digit buffer, error flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= '0;
      count      <= '0;
      discarding <= 1'b0;
    end else begin
      if (cmd.take) begin
        unique case (cls)
          CLS_DIGBUF: count <= count + 1'b1;
          CLS_BASE:   if (run != '1) run <= run + 1'b1;
          CLS_ERR: begin
            discarding <= 1'b1;
            run        <= '0;
            count      <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.conv_start) run <= '0;
      if (cmd.finish) begin
        run   <= '0;
        count <= '0;
        if (eos_q) discarding <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && cls == CLS_DIGBUF) digits[count[IdxW-1:0]] <= ecig_char[3:0];
    if (cmd.take) begin
      c_q   <= ecig_char;
      eos_q <= end_of_string;
      cls_q <= cls;
    end
  end

  // Shift-and-add-3 binary to decimal conversion, one bit per cycle.
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      sh       <= run;
      conv_cnt <= CcW'(RUN_WIDTH);
      num_ptr  <= NpW'(NumDig - 1);
      started  <= 1'b0;
      buf_ptr  <= '0;
      for (int i = 0; i < NumDig; i++) bcd[i] <= 4'd0;
    end else if (cmd.conv_step) begin
      sh       <= sh << 1;
      conv_cnt <= conv_cnt - 1'b1;
      bcd[0]   <= {adj[0][2:0], sh[RUN_WIDTH-1]};
      for (int i = 1; i < NumDig; i++) bcd[i] <= {adj[i][2:0], adj[i-1][3]};
    end
    if (cmd.num_adv) begin
      num_ptr <= num_ptr - 1'b1;
      if (cmd.emit) started <= 1'b1;
    end
    if (cmd.buf_adv) buf_ptr <= buf_ptr + 1'b1;
  end

  assign cur_dig = bcd[num_ptr];

  // Result register.
  always_comb begin
    pick_char = 8'h00;
    pick_has  = 1'b1;
    pick_err  = 1'b0;
    unique case (cmd.sel)
      SEL_NUM: pick_char = {DIGIT_HI, cur_dig};
      SEL_X:   pick_char = CH_X;
      SEL_BUF: pick_char = {DIGIT_HI, digits[buf_ptr[IdxW-1:0]]};
      SEL_ONE: begin
        unique case (cls_q)
          CLS_PASS: pick_char = c_q;
          CLS_MAP:  pick_char = map_char(c_q);
          CLS_ERR: begin
            pick_has = 1'b0;
            pick_err = 1'b1;
          end
          default:  pick_has = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_char <= pick_char;
      res_has  <= pick_has;
      res_err  <= pick_err;
      res_last <= cmd.last;
      res_eor  <= cmd.eor;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.cigar_char    = res_char;
  assign out_ch.has_char      = res_has;
  assign out_ch.is_error      = res_err;
  assign out_ch.last_of_run   = res_last;
  assign out_ch.end_of_record = res_eor;

  assign stat.cls       = cls;
  assign stat.eos_in    = end_of_string;
  assign stat.eos_q     = eos_q;
  assign stat.run_nz    = run_nz;
  assign stat.slot_free = !out_valid || out_ch.ready;
  assign stat.conv_done = (conv_cnt == '0);
  assign stat.num_skip  = !started && (cur_dig == 4'd0) && (num_ptr != '0);
  assign stat.num_zero  = (num_ptr == '0);
  assign stat.buf_end   = (buf_ptr == count);

endmodule

FILE: sv/ectc_ctrl.sv
// Controller of the transcoder: sequences intake, conversion and result emission.
module ectc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ectc_pkg::dp_stat_t   stat,
  output ectc_pkg::ctrl_cmd_t  cmd
);
  import ectc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EOSCHK = 3'd1;
  localparam logic [2:0] S_CONV   = 3'd2;
  localparam logic [2:0] S_NUM    = 3'd3;
  localparam logic [2:0] S_XCH    = 3'd4;
  localparam logic [2:0] S_BUF    = 3'd5;
  localparam logic [2:0] S_ONE    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       with_dig;
  logic       with_dig_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      with_dig <= 1'b0;
    end else begin
      state    <= state_next;
      with_dig <= with_dig_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.sel       = SEL_ONE;
    state_next    = state;
    with_dig_next = with_dig;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (stat.cls)
            CLS_MAP: begin
              if (stat.run_nz) begin
                cmd.conv_start = 1'b1;
                with_dig_next  = 1'b1;
                state_next     = S_CONV;
              end else begin
                state_next = S_ONE;
              end
            end
            CLS_PASS, CLS_ERR: state_next = S_ONE;
            default: if (stat.eos_in) state_next = S_EOSCHK;
          endcase
        end
      end
      S_EOSCHK: begin
        if (stat.run_nz) begin
          cmd.conv_start = 1'b1;
          with_dig_next  = 1'b0;
          state_next     = S_CONV;
        end else begin
          state_next = S_ONE;
        end
      end
      S_CONV: begin
        if (stat.conv_done) state_next = S_NUM;
        else cmd.conv_step = 1'b1;
      end
      S_NUM: begin
        if (stat.num_skip) begin
          cmd.num_adv = 1'b1;
        end else if (stat.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_NUM;
          cmd.num_adv = 1'b1;
          if (stat.num_zero) state_next = S_XCH;
        end
      end
      S_XCH: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_X;
          if (with_dig) begin
            state_next = S_BUF;
          end else begin
            cmd.last   = 1'b1;
            cmd.eor    = stat.eos_q;
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_BUF: begin
        if (stat.buf_end) begin
          state_next = S_ONE;
        end else if (stat.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_BUF;
          cmd.buf_adv = 1'b1;
        end
      end
      S_ONE: begin
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_ONE;
          cmd.last   = 1'b1;
          cmd.eor    = stat.eos_q;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
